// File: rtl/mppo_pkg.sv
// Shared widths, register indexes, reset values and payload types of the MPPT block.
`default_nettype none

package mppo_pkg;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned VOLT_BITS_DEF = 20;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned REF_W         = 20;
  localparam int unsigned POWER_W       = 40;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  localparam logic [GAIN_W-1:0]  SCALE_GAIN_RST  = 16'd256;
  localparam logic [REF_W-1:0]   STEP_SMALL_RST  = 20'd64;
  localparam logic [REF_W-1:0]   STEP_SWEEP_RST  = 20'd256;
  localparam logic [REF_W-1:0]   SWEEP_FLOOR_RST = 20'd0;
  localparam logic [REF_W-1:0]   SWEEP_CEIL_RST  = 20'hFFFFF;
  localparam logic [COUNT_W-1:0] HOLD_THR_RST    = 16'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_GAIN    = 3'd0,
    REG_STEP_SMALL    = 3'd1,
    REG_STEP_SWEEP    = 3'd2,
    REG_SWEEP_FLOOR   = 3'd3,
    REG_SWEEP_CEILING = 3'd4,
    REG_HOLD_THR      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] voltage_raw;
    logic [SAMPLE_BITS-1:0] current_raw;
    logic [COUNT_W-1:0]     interval_count;
    logic                   sweep_armed;
  } in_item_t;

  typedef struct packed {
    logic [REF_W-1:0]   voltage_ref;
    logic [POWER_W-1:0] power_now;
    logic               sweep_finished;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/mppt_perturb_observe_sweep.sv
// Perturb and observe MPPT with global sweep, built around one shared multiplier.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//  sample   | in_valid_i, in_ready_o, in_item_i         | in
//  result   | out_valid_o, out_ready_i, out_item_o      | out
//
// An item occupies the block from acceptance until the sequencer returns to idle:
// the single multiplier runs four times (voltage scale, current scale, power,
// sweep offset) in S_MV, S_MI, S_MP and S_MS, then the update state S_UPD writes the
// result. The result sits in an output register, so a new item is taken
// while it waits; the update cycle holds until that register is free.
// Reset (async, active low) returns the sequencer, tracker state and config registers to their reset values.
`default_nettype none

module mppt_perturb_observe_sweep #(
  parameter int unsigned VOLT_BITS = mppo_pkg::VOLT_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [mppo_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [((VOLT_BITS > mppo_pkg::GAIN_W) ?
                 VOLT_BITS : mppo_pkg::GAIN_W)-1:0]     cfg_data_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  mppo_pkg::in_item_t                            in_item_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output mppo_pkg::out_item_t                           out_item_o
);
  import mppo_pkg::*;

  localparam int unsigned MUL_W  = (VOLT_BITS > GAIN_W) ? VOLT_BITS : GAIN_W;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam logic [VOLT_BITS-1:0] VOLT_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MV   = 6'b000010,
    S_MI   = 6'b000100,
    S_MP   = 6'b001000,
    S_MS   = 6'b010000,
    S_UPD  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [GAIN_W-1:0]    gain_q;
  logic [VOLT_BITS-1:0] step_small_q, step_sweep_q, floor_q, ceil_q;
  logic [COUNT_W-1:0]   hold_q;

  // datapath registers
  in_item_t             in_q;
  logic [PROD_W-1:0]    prod_q;
  logic [VOLT_BITS-1:0] v_q;
  logic [POWER_W-1:0]   p_q;

  // tracker state
  logic [VOLT_BITS-1:0] last_v_q, ref_now_q, ref_before_q, best_ref_q;
  logic [POWER_W-1:0]   last_p_q, best_p_q;
  logic [COUNT_W-1:0]   steps_q;

  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 in_fire, upd_go;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_res, sc_full;
  logic [VOLT_BITS-1:0] sc_sat;
  logic [PROD_W+POWER_W-1:0] pw_ext;
  logic [POWER_W-1:0]   p_sat;
  logic                 track, rising, p_gt, p_eq;
  logic [VOLT_BITS:0]   up_sum;
  logic [VOLT_BITS-1:0] ref_up, ref_dn, ref_trk;
  logic [COUNT_W-1:0]   steps_inc;
  logic [PROD_W:0]      sw_sum;
  logic [VOLT_BITS-1:0] ref_sw, best_ref_nx, ref_new;
  logic                 best_hit, sw_end, fin;
  logic [VOLT_BITS+REF_W-1:0] ref_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign upd_go      = (state_q == S_UPD) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MV;
      S_MV:    state_d = S_MI;
      S_MI:    state_d = S_MP;
      S_MP:    state_d = S_MS;
      S_MS:    state_d = S_UPD;
      S_UPD:   if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // scale: (raw * gain) >> 8, saturated to the reference range
  assign sc_full = prod_q >> FRAC_BITS;
  assign sc_sat  = (sc_full > PROD_W'(VOLT_MAX)) ? VOLT_MAX : sc_full[VOLT_BITS-1:0];

  assign steps_inc = steps_q + 1'b1;

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_MV: begin
        mul_a = MUL_W'(in_q.voltage_raw);
        mul_b = MUL_W'(gain_q);
      end
      S_MI: begin
        mul_a = MUL_W'(in_q.current_raw);
        mul_b = MUL_W'(gain_q);
      end
      S_MP: begin
        mul_a = MUL_W'(v_q);
        mul_b = MUL_W'(sc_sat);
      end
      S_MS: begin
        mul_a = MUL_W'(step_sweep_q);
        mul_b = MUL_W'(steps_inc);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  assign pw_ext = (PROD_W + POWER_W)'(prod_q);
  assign p_sat  = (pw_ext > (PROD_W + POWER_W)'(POWER_MAX)) ? POWER_MAX
                                                            : pw_ext[POWER_W-1:0];

  // perturb and observe decision
  assign track  = in_q.interval_count < hold_q;
  assign rising = v_q > last_v_q;
  assign p_gt   = p_q > last_p_q;
  assign p_eq   = p_q == last_p_q;
  assign up_sum = {1'b0, ref_before_q} + {1'b0, step_small_q};
  assign ref_up = up_sum[VOLT_BITS] ? VOLT_MAX : up_sum[VOLT_BITS-1:0];
  assign ref_dn = (step_small_q > ref_before_q) ? '0 : ref_before_q - step_small_q;

  always_comb begin
    if (p_gt) begin
      ref_trk = rising ? ref_up : ref_dn;
    end else if (p_eq) begin
      ref_trk = ref_before_q;
    end else begin
      ref_trk = rising ? ref_dn : ref_up;
    end
  end

  // sweep: floor + step_sweep * steps, saturated
  assign sw_sum      = {1'b0, prod_q} + (PROD_W + 1)'(floor_q);
  assign ref_sw      = (sw_sum > (PROD_W + 1)'(VOLT_MAX)) ? VOLT_MAX
                                                          : sw_sum[VOLT_BITS-1:0];
  assign best_hit    = p_q > best_p_q;
  assign best_ref_nx = best_hit ? ref_now_q : best_ref_q;
  assign sw_end      = ref_sw >= ceil_q;
  assign fin         = !track && in_q.sweep_armed && sw_end;

  always_comb begin
    if (track) begin
      ref_new = ref_trk;
    end else if (in_q.sweep_armed) begin
      ref_new = sw_end ? best_ref_nx : ref_sw;
    end else begin
      ref_new = ref_now_q;
    end
  end

  assign ref_ext = (VOLT_BITS + REF_W)'(ref_new);

  // control and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      gain_q       <= SCALE_GAIN_RST;
      step_small_q <= VOLT_BITS'(STEP_SMALL_RST);
      step_sweep_q <= VOLT_BITS'(STEP_SWEEP_RST);
      floor_q      <= VOLT_BITS'(SWEEP_FLOOR_RST);
      ceil_q       <= VOLT_BITS'(SWEEP_CEIL_RST);
      hold_q       <= HOLD_THR_RST;
      last_v_q     <= '0;
      last_p_q     <= '0;
      ref_now_q    <= '0;
      ref_before_q <= '0;
      steps_q      <= '0;
      best_ref_q   <= '0;
      best_p_q     <= '0;
    end else begin
      state_q <= state_d;

      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SCALE_GAIN:    gain_q       <= cfg_data_i[GAIN_W-1:0];
          REG_STEP_SMALL:    step_small_q <= cfg_data_i[VOLT_BITS-1:0];
          REG_STEP_SWEEP:    step_sweep_q <= cfg_data_i[VOLT_BITS-1:0];
          REG_SWEEP_FLOOR:   floor_q      <= cfg_data_i[VOLT_BITS-1:0];
          REG_SWEEP_CEILING: ceil_q       <= cfg_data_i[VOLT_BITS-1:0];
          REG_HOLD_THR:      hold_q       <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (upd_go) begin
        if (track) begin
          ref_now_q    <= ref_trk;
          ref_before_q <= ref_trk;
          last_v_q     <= v_q;
          last_p_q     <= p_q;
        end else if (in_q.sweep_armed) begin
          if (best_hit) begin
            best_p_q <= p_q;
          end
          best_ref_q <= best_ref_nx;
          if (sw_end) begin
            steps_q      <= '0;
            ref_now_q    <= best_ref_nx;
            ref_before_q <= best_ref_nx;
          end else begin
            steps_q      <= steps_inc;
            ref_now_q    <= ref_sw;
            ref_before_q <= ref_now_q;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_i;
    end
    if ((state_q == S_MV) || (state_q == S_MI) || (state_q == S_MP) ||
        (state_q == S_MS)) begin
      prod_q <= mul_res;
    end
    if (state_q == S_MI) begin
      v_q <= sc_sat;
    end
    if (state_q == S_MS) begin
      p_q <= p_sat;
    end
    if (upd_go) begin
      out_q.voltage_ref    <= ref_ext[REF_W-1:0];
      out_q.power_now      <= p_q;
      out_q.sweep_finished <= fin;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MV) && !in_ready_o)
    else $error("accepted item did not start the multiply sequence");

  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && fin) |=> (steps_q == '0) && (ref_now_q == best_ref_q) &&
                        (ref_before_q == best_ref_q))
    else $error("sweep end did not restore best reference");

  a_track_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && track) |=> (ref_before_q == ref_now_q) && (last_p_q == $past(p_q)))
    else $error("tracking update left reference or power out of step");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && !track && !in_q.sweep_armed) |=>
      $stable(ref_now_q) && $stable(best_p_q) && $stable(steps_q))
    else $error("idle item changed tracker state");
`endif

endmodule

`default_nettype wire

// File: tb/mppt_perturb_observe_sweep_checker.sv
// Checker for the MPPT block: tracks configuration, predicts each result and compares.
`timescale 1ns / 100ps

module mppt_perturb_observe_sweep_checker #(
  parameter int unsigned CFG_W = (mppo_pkg::REF_W > mppo_pkg::GAIN_W) ? mppo_pkg::REF_W
                                                                     : mppo_pkg::GAIN_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mppo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  mppo_pkg::in_item_t             in_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  mppo_pkg::out_item_t            out_item_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o
);
  import mppo_pkg::*;

  localparam logic [63:0] REF_MAX = (64'd1 << REF_W) - 64'd1;

  // register copies
  logic [GAIN_W-1:0]  gain_q8;
  logic [REF_W-1:0]   track_step;
  logic [REF_W-1:0]   ramp_step;
  logic [REF_W-1:0]   ramp_start;
  logic [REF_W-1:0]   ramp_stop;
  logic [COUNT_W-1:0] hold_thr;

  // tracker state
  logic [REF_W-1:0]   prev_volt;
  logic [POWER_W-1:0] prev_power;
  logic [REF_W-1:0]   ref_now;
  logic [REF_W-1:0]   ref_prev;
  logic [COUNT_W-1:0] ramp_count;
  logic [REF_W-1:0]   best_ref;
  logic [POWER_W-1:0] best_power;

  out_item_t expected_results[$];

  function automatic logic [63:0] clip_ref(input logic [63:0] x);
    return (x > REF_MAX) ? REF_MAX : x;
  endfunction

  function automatic logic [63:0] scale_raw(input logic [SAMPLE_BITS-1:0] raw);
    return clip_ref((64'(raw) * 64'(gain_q8)) >> FRAC_BITS);
  endfunction

  function automatic logic [63:0] ref_raise(input logic [63:0] base, input logic [63:0] d);
    return clip_ref(base + d);
  endfunction

  function automatic logic [63:0] ref_lower(input logic [63:0] base, input logic [63:0] d);
    return (d > base) ? 64'd0 : base - d;
  endfunction

  // Advance the tracker by one sample and return the result it reports.
  function automatic out_item_t track_sample(input in_item_t s);
    logic [63:0] volt;
    logic [63:0] curr;
    logic [63:0] pwr;
    logic [63:0] nxt;
    logic [63:0] base;
    logic [63:0] d;
    logic        rising;
    logic        ended;
    out_item_t   res;
    volt  = scale_raw(s.voltage_raw);
    curr  = scale_raw(s.current_raw);
    pwr   = volt * curr;
    ended = 1'b0;
    if (pwr > 64'(POWER_MAX)) pwr = 64'(POWER_MAX);
    if (s.interval_count < hold_thr) begin
      rising = volt > 64'(prev_volt);
      base   = 64'(ref_prev);
      d      = 64'(track_step);
      if (pwr > 64'(prev_power)) begin
        nxt = rising ? ref_raise(base, d) : ref_lower(base, d);
      end else if (pwr == 64'(prev_power)) begin
        nxt = base;
      end else begin
        nxt = rising ? ref_lower(base, d) : ref_raise(base, d);
      end
      ref_now    = nxt[REF_W-1:0];
      ref_prev   = nxt[REF_W-1:0];
      prev_volt  = volt[REF_W-1:0];
      prev_power = pwr[POWER_W-1:0];
    end else if (s.sweep_armed) begin
      ref_prev   = ref_now;
      ramp_count = ramp_count + 1'b1;
      nxt        = clip_ref(64'(ramp_start) + 64'(ramp_step) * 64'(ramp_count));
      ref_now    = nxt[REF_W-1:0];
      if (pwr > 64'(best_power)) begin
        best_ref   = ref_prev;
        best_power = pwr[POWER_W-1:0];
      end
      if (ref_now >= ramp_stop) begin
        ramp_count = '0;
        ref_now    = best_ref;
        ref_prev   = best_ref;
        ended      = 1'b1;
      end
    end
    res.voltage_ref    = ref_now;
    res.power_now      = pwr[POWER_W-1:0];
    res.sweep_finished = ended;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches_o++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      gain_q8      = SCALE_GAIN_RST;
      track_step   = STEP_SMALL_RST;
      ramp_step    = STEP_SWEEP_RST;
      ramp_start   = SWEEP_FLOOR_RST;
      ramp_stop    = SWEEP_CEIL_RST;
      hold_thr     = HOLD_THR_RST;
      prev_volt    = '0;
      prev_power   = '0;
      ref_now      = '0;
      ref_prev     = '0;
      ramp_count   = '0;
      best_ref     = '0;
      best_power   = '0;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // compare first: a result leaving on this edge cannot belong to an item entering on it
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with no item pending: expected none, actual ref %0d power %0d fin %0b",
                   $time, out_item_i.voltage_ref, out_item_i.power_now,
                   out_item_i.sweep_finished);
        end else begin
          want = expected_results.pop_front();
          check_field("voltage_ref", 64'(want.voltage_ref), 64'(out_item_i.voltage_ref));
          check_field("power_now", 64'(want.power_now), 64'(out_item_i.power_now));
          check_field("sweep_finished", 64'(want.sweep_finished),
                      64'(out_item_i.sweep_finished));
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(track_sample(in_item_i));
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SCALE_GAIN:    gain_q8    = cfg_data_i[GAIN_W-1:0];
          REG_STEP_SMALL:    track_step = cfg_data_i[REF_W-1:0];
          REG_STEP_SWEEP:    ramp_step  = cfg_data_i[REF_W-1:0];
          REG_SWEEP_FLOOR:   ramp_start = cfg_data_i[REF_W-1:0];
          REG_SWEEP_CEILING: ramp_stop  = cfg_data_i[REF_W-1:0];
          REG_HOLD_THR:      hold_thr   = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: tb/mppt_perturb_observe_sweep_test.sv
// Top of the MPPT testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module mppt_perturb_observe_sweep_test;
  import mppo_pkg::*;

  localparam int unsigned CFG_W         = (REF_W > GAIN_W) ? REF_W : GAIN_W;
  localparam int unsigned LIMIT_CYCLES  = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned REF_TOP       = (1 << REF_W) - 1;

  typedef enum int unsigned {KIND_TRACK, KIND_SWEEP, KIND_HOLD, KIND_NOISE} sample_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  cfg_reg_e             cfg_idx   = REG_SCALE_GAIN;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_item   = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 calm      = 1'b0;
  in_item_t             last_sample = '0;
  logic [CFG_W-1:0]     reg_shadow [6];
  int unsigned          cycles    = 0;
  int unsigned          mismatches;
  int unsigned          pending;

  always #6 clk = ~clk;

  mppt_perturb_observe_sweep DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  mppt_perturb_observe_sweep_checker #(.CFG_W(CFG_W)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[mppt_perturb_observe_sweep] ERROR");
      $finish;
    end
  end

  function automatic in_item_t sample(input int unsigned v, input int unsigned c,
                                      input int unsigned cnt, input bit arm);
    in_item_t s;
    s.voltage_raw    = v[SAMPLE_BITS-1:0];
    s.current_raw    = c[SAMPLE_BITS-1:0];
    s.interval_count = cnt[COUNT_W-1:0];
    s.sweep_armed    = arm;
    return s;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] nudge(input logic [SAMPLE_BITS-1:0] base);
    int val;
    val = int'(base) + int'($urandom_range(16)) - 8;
    if (val < 0) val = 0;
    if (val > int'(SAMPLE_MAX)) val = int'(SAMPLE_MAX);
    return SAMPLE_BITS'(val);
  endfunction

  // Random sample of the given kind; content often stays near the previous one
  // so that equal and slowly changing power show up.
  function automatic in_item_t make_sample(input sample_kind_e kind);
    in_item_t    s;
    int unsigned r;
    int unsigned thr;
    thr = 32'(reg_shadow[REG_HOLD_THR][COUNT_W-1:0]);
    r = $urandom_range(99);
    s = last_sample;
    if (r < 40 && r >= 10) begin
      s.voltage_raw = nudge(last_sample.voltage_raw);
      s.current_raw = nudge(last_sample.current_raw);
    end else if (r < 50 && r >= 40) begin
      s.voltage_raw = $urandom_range(1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
      s.current_raw = $urandom_range(1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
    end else if (r >= 50) begin
      s.voltage_raw = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      s.current_raw = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
    end
    s.sweep_armed = 1'($urandom_range(1));
    case (kind)
      KIND_TRACK: s.interval_count = COUNT_W'((thr == 0) ? $urandom_range(65535)
                                                         : $urandom_range(thr - 1, 0));
      KIND_SWEEP: begin
        s.interval_count = COUNT_W'($urandom_range(65535, thr));
        s.sweep_armed    = 1'b1;
      end
      KIND_HOLD: begin
        s.interval_count = COUNT_W'($urandom_range(65535, thr));
        s.sweep_armed    = 1'b0;
      end
      default: s.interval_count = COUNT_W'($urandom_range(65535));
    endcase
    last_sample = s;
    return s;
  endfunction

  // Entered and left at a falling edge; valid stays up into the next offer unless a random gap drops it.
  task automatic offer_sample(input in_item_t s);
    in_valid <= 1'b1;
    in_item  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  // Drop valid, drain every pending result, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_regs();
    settle();
    for (int k = 0; k < 6; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(k);
      cfg_data <= reg_shadow[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    apply_regs();
    // tracking: up from zero, down, clamp at zero, hold on equal power
    offer_sample(sample(10, 10, 0, 0));
    offer_sample(sample(5, 100, 0, 1));
    offer_sample(sample(3, 1000, 1, 0));
    offer_sample(sample(3, 1000, 9999, 0));
    offer_sample(sample(SAMPLE_MAX, SAMPLE_MAX, 0, 1));
    offer_sample(sample(SAMPLE_MAX, 100, 2, 0));
    offer_sample(sample(100, SAMPLE_MAX, 3, 0));
    offer_sample(sample(SAMPLE_MAX, 0, 4, 0));
    // idle: count at threshold, nothing armed
    offer_sample(sample(0, 0, 10000, 0));
    offer_sample(sample(SAMPLE_MAX, SAMPLE_MAX, 65535, 0));
    // large tracking step: clamp low, then saturate high
    reg_shadow[REG_STEP_SMALL] = CFG_W'(REF_TOP);
    apply_regs();
    offer_sample(sample(SAMPLE_MAX, SAMPLE_MAX, 0, 0));
    offer_sample(sample(0, 1, 0, 0));
    // short sweep, then a weaker one that must keep the old best reference
    reg_shadow[REG_SWEEP_FLOOR]   = CFG_W'(1000);
    reg_shadow[REG_STEP_SWEEP]    = CFG_W'(500);
    reg_shadow[REG_SWEEP_CEILING] = CFG_W'(2500);
    apply_regs();
    offer_sample(sample(2000, 2000, 10000, 1));
    offer_sample(sample(SAMPLE_MAX, SAMPLE_MAX, 10001, 1));
    offer_sample(sample(100, 100, 65535, 1));
    offer_sample(sample(1, 1, 10000, 1));
    offer_sample(sample(2, 2, 20000, 1));
    offer_sample(sample(3, 3, 30000, 1));
    // ceiling below floor ends the sweep on its first step
    reg_shadow[REG_SWEEP_CEILING] = CFG_W'(500);
    apply_regs();
    offer_sample(sample(SAMPLE_MAX, SAMPLE_MAX, 10000, 1));
    offer_sample(sample(7, 9, 9999, 1));
  endtask

  task automatic pick_config(input int unsigned ph);
    int unsigned lo;
    int unsigned hi;
    int unsigned span;
    int unsigned stp;
    if (ph == 0) begin
      reg_shadow[REG_SCALE_GAIN]    = CFG_W'(16'hFFFF);
      reg_shadow[REG_STEP_SMALL]    = CFG_W'(REF_TOP);
      reg_shadow[REG_STEP_SWEEP]    = CFG_W'(REF_TOP);
      reg_shadow[REG_SWEEP_FLOOR]   = CFG_W'(REF_TOP);
      reg_shadow[REG_SWEEP_CEILING] = CFG_W'(REF_TOP);
      reg_shadow[REG_HOLD_THR]      = CFG_W'(16'hFFFF);
    end else if (ph == 1) begin
      foreach (reg_shadow[k]) reg_shadow[k] = '0;
    end else begin
      reg_shadow[REG_SCALE_GAIN] = CFG_W'(($urandom_range(99) < 15) ? 0 :
                                          ($urandom_range(99) < 20) ? 65535 :
                                          $urandom_range(65535, 1));
      reg_shadow[REG_STEP_SMALL] = CFG_W'(($urandom_range(99) < 15) ? 0 :
                                          ($urandom_range(99) < 15) ? REF_TOP :
                                          $urandom_range(4096));
      lo = ($urandom_range(99) < 25) ? 0 : $urandom_range(REF_TOP);
      hi = ($urandom_range(99) < 20) ? REF_TOP :
           ($urandom_range(99) < 10) ? 0 : $urandom_range(REF_TOP, lo);
      span = (hi > lo) ? hi - lo : 0;
      stp  = span / $urandom_range(25, 1) + 1;
      if ($urandom_range(99) < 10) stp = REF_TOP;
      if ($urandom_range(99) < 5) stp = 0;
      if (stp > REF_TOP) stp = REF_TOP;
      reg_shadow[REG_SWEEP_FLOOR]   = CFG_W'(lo);
      reg_shadow[REG_SWEEP_CEILING] = CFG_W'(hi);
      reg_shadow[REG_STEP_SWEEP]    = CFG_W'(stp);
      reg_shadow[REG_HOLD_THR]      = CFG_W'(($urandom_range(99) < 15) ? 0 :
                                             ($urandom_range(99) < 15) ? 65535 :
                                             $urandom_range(65535));
    end
  endtask

  task automatic run_random();
    int unsigned  sent;
    int unsigned  r;
    int unsigned  len;
    sample_kind_e kind;
    bit           drained;
    drained = 1'b0;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_config(ph);
      apply_regs();
      calm = (ph == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 50) begin
          kind = KIND_TRACK;
          len  = $urandom_range(12, 1);
        end else if (r < 85) begin
          kind = KIND_SWEEP;
          len  = $urandom_range(30, 1);
        end else begin
          kind = (r < 93) ? KIND_HOLD : KIND_NOISE;
          len  = $urandom_range(3, 1);
        end
        repeat (len) offer_sample(make_sample(kind));
        sent += len;
        // hold the sender once until the block has caught up
        if (ph == 3 && !drained && sent > PHASE_ITEMS / 2) begin
          drained = 1'b1;
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reg_shadow[REG_SCALE_GAIN]    = CFG_W'(SCALE_GAIN_RST);
    reg_shadow[REG_STEP_SMALL]    = CFG_W'(STEP_SMALL_RST);
    reg_shadow[REG_STEP_SWEEP]    = CFG_W'(STEP_SWEEP_RST);
    reg_shadow[REG_SWEEP_FLOOR]   = CFG_W'(SWEEP_FLOOR_RST);
    reg_shadow[REG_SWEEP_CEILING] = CFG_W'(SWEEP_CEIL_RST);
    reg_shadow[REG_HOLD_THR]      = CFG_W'(HOLD_THR_RST);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[mppt_perturb_observe_sweep] OK");
    end else begin
      $display("[mppt_perturb_observe_sweep] ERROR");
    end
    $finish;
  end

endmodule
